// ===== hdl/weno5_pkg.sv =====
`timescale 1ns / 1ps
package weno5_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 24;

  // Internal words follow 64-bit modular arithmetic.
  localparam int ACC_W     = 64;
  localparam int EXP_W     = 12;
  localparam int MANT_BITS = 14;
  localparam int SQ_BITS   = 28;
  localparam int SH_W      = 6;
  localparam int LEN_W     = 7;

  // round(12e-6 * 2^40)
  localparam logic [ACC_W-1:0] EPS_MANT = 64'd13194140;

  localparam logic [2:0] D10_R [3] = '{3'd3, 3'd6, 3'd1};
  localparam logic [2:0] D10_L [3] = '{3'd1, 3'd6, 3'd3};
  localparam int PAIR_S [3] = '{1, 2, 0};
  localparam int PAIR_T [3] = '{2, 0, 1};

  typedef struct packed {
    logic [ACC_W-1:0]        m;
    logic signed [EXP_W-1:0] e;
  } pf_t;

  typedef struct packed {
    logic [MANT_BITS-1:0]    m;
    logic signed [EXP_W-1:0] e;
  } nf_t;

  function automatic logic [LEN_W-1:0] bit_len(input logic [ACC_W-1:0] x);
    logic [LEN_W-1:0] n;
    n = '0;
    for (int i = 0; i < ACC_W; i++) begin
      if (x[i]) n = LEN_W'(i + 1);
    end
    return n;
  endfunction

  function automatic logic [ACC_W-1:0] shift_down(input logic [ACC_W-1:0] m,
                                                  input logic [EXP_W:0] d);
    logic [ACC_W-1:0] r;
    if (d >= (EXP_W+1)'(ACC_W)) r = '0;
    else r = m >> d[SH_W-1:0];
    return r;
  endfunction

  function automatic pf_t pf_add(input pf_t a, input pf_t b);
    pf_t r;
    logic signed [EXP_W:0] d;
    logic signed [EXP_W:0] nd;
    d  = {a.e[EXP_W-1], a.e} - {b.e[EXP_W-1], b.e};
    nd = -d;
    r  = a;
    if (a.m == '0) begin
      r = b;
    end else if (b.m == '0) begin
      r = a;
    end else if (d >= 0) begin
      r.m = a.m + shift_down(b.m, d);
    end else begin
      r   = b;
      r.m = b.m + shift_down(a.m, nd);
    end
    return r;
  endfunction

  function automatic nf_t pf_norm(input pf_t a);
    nf_t r;
    logic [LEN_W-1:0] len;
    len = bit_len(a.m);
    if (a.m == '0) begin
      r.m = MANT_BITS'(1) << (MANT_BITS - 1);
      r.e = a.e;
    end else if (len > LEN_W'(MANT_BITS)) begin
      r.m = MANT_BITS'(a.m >> (len - LEN_W'(MANT_BITS)));
      r.e = a.e + EXP_W'(len - LEN_W'(MANT_BITS));
    end else begin
      r.m = MANT_BITS'(a.m << (LEN_W'(MANT_BITS) - len));
      r.e = a.e - EXP_W'(LEN_W'(MANT_BITS) - len);
    end
    return r;
  endfunction

endpackage

// ===== hdl/weno5_in_if.sv =====
`timescale 1ns / 1ps
interface weno5_in_if #(
  parameter int DATA_WIDTH = weno5_pkg::DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] cell_minus_two;
  logic signed [DATA_WIDTH-1:0] cell_minus_one;
  logic signed [DATA_WIDTH-1:0] cell_center;
  logic signed [DATA_WIDTH-1:0] cell_plus_one;
  logic signed [DATA_WIDTH-1:0] cell_plus_two;

  modport source (output valid, cell_minus_two, cell_minus_one, cell_center,
                  cell_plus_one, cell_plus_two, input ready);
  modport sink   (input valid, cell_minus_two, cell_minus_one, cell_center,
                  cell_plus_one, cell_plus_two, output ready);
endinterface

// ===== hdl/weno5_out_if.sv =====
`timescale 1ns / 1ps
interface weno5_out_if #(
  parameter int DATA_WIDTH = weno5_pkg::DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] right_face_value;
  logic signed [DATA_WIDTH-1:0] left_face_value;

  modport source (output valid, right_face_value, left_face_value, input ready);
  modport sink   (input valid, right_face_value, left_face_value, output ready);
endinterface

// ===== hdl/weno5_div.sv =====
`timescale 1ns / 1ps
module weno5_div #(
  parameter int NUM_W = weno5_pkg::ACC_W,
  parameter int DEN_W = 46
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic             neg_i,
  output logic             valid_o,
  output logic [NUM_W-1:0] quo_o,
  output logic             neg_o
);
  // One quotient bit per stage, restoring form.
  logic [NUM_W-1:0] quo_q [NUM_W];
  logic [DEN_W-1:0] rem_q [NUM_W-1];
  logic [DEN_W-1:0] den_q [NUM_W-1];
  logic             neg_q [NUM_W];
  logic             vld_q [NUM_W];

  for (genvar i = 0; i < NUM_W; i++) begin : g_stage
    logic [DEN_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [NUM_W-1:0] quo_in;
    logic             vld_in;
    logic             neg_in;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             take;

    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign den_in = den_i;
      assign quo_in = num_i;
      assign vld_in = valid_i;
      assign neg_in = neg_i;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign den_in = den_q[i-1];
      assign quo_in = quo_q[i-1];
      assign vld_in = vld_q[i-1];
      assign neg_in = neg_q[i-1];
    end

    assign trial = {rem_in, quo_in[NUM_W-1]};
    assign take  = trial >= {1'b0, den_in};
    assign diff  = trial - {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[i] <= {quo_in[NUM_W-2:0], take};
        neg_q[i] <= neg_in;
      end
    end

    if (i < NUM_W - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[i] <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
          den_q[i] <= den_in;
        end
      end
    end
  end

  assign valid_o = vld_q[NUM_W-1];
  assign quo_o   = quo_q[NUM_W-1];
  assign neg_o   = neg_q[NUM_W-1];
endmodule

// ===== hdl/weno5_face_reconstruction.sv =====
`timescale 1ns / 1ps
// WENO5-JS face reconstruction. Each beat on in_i carries a window of five
// Q(DATA_WIDTH-FRAC_BITS).FRAC_BITS cell averages; the matching beat on out_o
// carries the saturated right and left face values of the center cell. The
// block is a fully pipelined datapath that takes one window every clock cycle
// while out_o is not stalled: 14 stages build the smoothness indicators,
// nonlinear weights and weighted sums, 64 stages form the quotient one bit
// each (one divider per face), and one output register holds the result.
// Results keep input order. When out_o is stalled the whole pipeline holds,
// so in_i.ready follows the output side.
module weno5_face_reconstruction #(
  parameter int DATA_WIDTH = weno5_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = weno5_pkg::FRAC_BITS_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  weno5_in_if.sink    in_i,
  weno5_out_if.source out_o
);
  import weno5_pkg::*;

  localparam int EPS_EXP     = 2 * FRAC_BITS - 40;
  localparam int WB_RAW      = 58 - DATA_WIDTH;
  localparam int WEIGHT_BITS = WB_RAW < 24 ? 24 : (WB_RAW > 40 ? 40 : WB_RAW);
  localparam int DEN_BITS    = WEIGHT_BITS + 2;
  localparam int DIV_DEN_W   = WEIGHT_BITS + 6;
  localparam int NSTG        = 14;
  localparam logic [ACC_W-1:0] LIM = (ACC_W'(1) << (DATA_WIDTH - 1)) - ACC_W'(1);
  localparam pf_t EPS_PF = '{m: EPS_MANT, e: EXP_W'(EPS_EXP)};

  logic en;
  logic [NSTG:1] v_q;

  // Window numerators, carried to the multiply stage.
  logic [ACC_W-1:0] n_q [1:11][6];

  logic [ACC_W-1:0]     dif1_q [6];
  logic [SQ_BITS-1:0]   u2_q   [6];
  logic [SH_W-1:0]      s2_q   [6];
  logic [2*SQ_BITS-1:0] sq3_q  [6];
  logic [SH_W-1:0]      s3_q   [6];
  pf_t                  pq4_q  [3];
  pf_t                  g5_q   [3];
  nf_t                  g6_q   [3];
  logic [2*MANT_BITS-1:0]  gm7_q [3];
  logic signed [EXP_W-1:0] ge7_q [3];
  logic [4*MANT_BITS-1:0]  pr8_q [3];
  logic signed [EXP_W-1:0] x8_q  [3];
  logic [ACC_W-1:0]        a9_q  [6];
  logic signed [EXP_W-1:0] x9_q  [3];
  logic signed [EXP_W-1:0] xmax9_q;
  logic [ACC_W-1:0]        a10_q [6];
  logic [ACC_W-1:0]        sum10_q [2];
  logic [WEIGHT_BITS-1:0]  aw11_q [6];
  logic [DEN_BITS-1:0]     den11_q [2];
  logic [ACC_W-1:0]        plo12_q [6];
  logic [31:0]             phi12_q [6];
  logic [DEN_BITS-1:0]     den12_q [2];
  logic [ACC_W-1:0]        num13_q [2];
  logic [DEN_BITS-1:0]     den13_q [2];
  logic [ACC_W-1:0]        dn14_q  [2];
  logic [DIV_DEN_W-1:0]    dd14_q  [2];
  logic                    neg14_q [2];

  logic                  div_v [2];
  logic [ACC_W-1:0]      div_q [2];
  logic                  div_n [2];
  logic [DATA_WIDTH-1:0] face_d [2];

  logic                  out_v_q;
  logic [DATA_WIDTH-1:0] right_q;
  logic [DATA_WIDTH-1:0] left_q;

  logic [ACC_W-1:0] v0, v1, v2, v3, v4;
  logic [ACC_W-1:0] dif_d [6];
  logic [ACC_W-1:0] nn_d  [6];

  // Hold everything while the output beat waits.
  assign en         = !out_v_q || out_o.ready;
  assign in_i.ready = en;

  always_comb begin
    v0 = ACC_W'(in_i.cell_minus_two);
    v1 = ACC_W'(in_i.cell_minus_one);
    v2 = ACC_W'(in_i.cell_center);
    v3 = ACC_W'(in_i.cell_plus_one);
    v4 = ACC_W'(in_i.cell_plus_two);
    dif_d[0] = v2 - (v3 << 1) + v4;
    dif_d[1] = ACC_W'(3) * v2 - (v3 << 2) + v4;
    dif_d[2] = v1 - (v2 << 1) + v3;
    dif_d[3] = v1 - v3;
    dif_d[4] = v0 - (v1 << 1) + v2;
    dif_d[5] = v0 - (v1 << 2) + ACC_W'(3) * v2;
    nn_d[0]  = (v2 << 1) + ACC_W'(5) * v3 - v4;
    nn_d[1]  = ACC_W'(5) * v2 + (v3 << 1) - v1;
    nn_d[2]  = (v0 << 1) - ACC_W'(7) * v1 + ACC_W'(11) * v2;
    nn_d[3]  = ACC_W'(11) * v2 - ACC_W'(7) * v3 + (v4 << 1);
    nn_d[4]  = (v1 << 1) + ACC_W'(5) * v2 - v3;
    nn_d[5]  = ACC_W'(5) * v1 + (v2 << 1) - v0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NSTG-1:1], in_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 6; j++) begin
        n_q[1][j] <= nn_d[j];
        dif1_q[j] <= dif_d[j];
      end
      for (int st = 2; st <= 11; st++) begin
        for (int j = 0; j < 6; j++) n_q[st][j] <= n_q[st-1][j];
      end
    end
  end

  // Truncate each difference to its leading bits ahead of the square.
  always_ff @(posedge clk_i) begin
    logic [ACC_W-1:0] mag;
    logic [LEN_W-1:0] len;
    logic [SH_W-1:0]  sh;
    if (en) begin
      for (int j = 0; j < 6; j++) begin
        mag = dif1_q[j][ACC_W-1] ? -dif1_q[j] : dif1_q[j];
        len = bit_len(mag);
        sh  = (len > LEN_W'(SQ_BITS)) ? SH_W'(len - LEN_W'(SQ_BITS)) : '0;
        u2_q[j] <= SQ_BITS'(mag >> sh);
        s2_q[j] <= sh;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 6; j++) begin
        sq3_q[j] <= u2_q[j] * u2_q[j];
        s3_q[j]  <= s2_q[j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pf_t p;
    pf_t q;
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        p.m = ACC_W'(sq3_q[2*r]) * ACC_W'(13);
        p.e = EXP_W'({s3_q[2*r], 1'b0});
        q.m = ACC_W'(sq3_q[2*r+1]) * ACC_W'(3);
        q.e = EXP_W'({s3_q[2*r+1], 1'b0});
        pq4_q[r] <= pf_add(p, q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        g5_q[r] <= pf_add(pq4_q[r], EPS_PF);
        g6_q[r] <= pf_norm(g5_q[r]);
        gm7_q[r] <= g6_q[r].m * g6_q[r].m;
        ge7_q[r] <= g6_q[r].e;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        pr8_q[r] <= gm7_q[PAIR_S[r]] * gm7_q[PAIR_T[r]];
        x8_q[r]  <= (ge7_q[PAIR_S[r]] + ge7_q[PAIR_T[r]]) <<< 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [EXP_W-1:0] xm;
    if (en) begin
      xm = x8_q[0];
      for (int r = 1; r < 3; r++) begin
        if (x8_q[r] > xm) xm = x8_q[r];
      end
      for (int r = 0; r < 3; r++) begin
        a9_q[r]   <= ACC_W'(pr8_q[r]) * ACC_W'(D10_R[r]);
        a9_q[r+3] <= ACC_W'(pr8_q[r]) * ACC_W'(D10_L[r]);
        x9_q[r]   <= x8_q[r];
      end
      xmax9_q <= xm;
    end
  end

  // Align the weight terms on the largest exponent.
  always_ff @(posedge clk_i) begin
    logic [EXP_W:0]   d;
    logic [ACC_W-1:0] al [6];
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        d = {xmax9_q[EXP_W-1], xmax9_q} - {x9_q[r][EXP_W-1], x9_q[r]};
        al[r]   = shift_down(a9_q[r], d);
        al[r+3] = shift_down(a9_q[r+3], d);
      end
      for (int j = 0; j < 6; j++) a10_q[j] <= al[j];
      sum10_q[0] <= al[0] + al[1] + al[2];
      sum10_q[1] <= al[3] + al[4] + al[5];
    end
  end

  // Scale the weights into WEIGHT_BITS.
  always_ff @(posedge clk_i) begin
    logic [LEN_W-1:0]       len;
    logic [LEN_W-1:0]       k;
    logic [WEIGHT_BITS-1:0] w [3];
    if (en) begin
      for (int f = 0; f < 2; f++) begin
        len = bit_len(sum10_q[f]);
        k   = (len > LEN_W'(WEIGHT_BITS)) ? len - LEN_W'(WEIGHT_BITS) : '0;
        for (int r = 0; r < 3; r++) begin
          w[r] = WEIGHT_BITS'(a10_q[3*f+r] >> k);
          aw11_q[3*f+r] <= w[r];
        end
        den11_q[f] <= DEN_BITS'(w[0]) + DEN_BITS'(w[1]) + DEN_BITS'(w[2]);
      end
    end
  end

  // Weight times numerator in two partial products, kept modulo 2^64.
  always_ff @(posedge clk_i) begin
    logic [ACC_W-1:0] hi;
    if (en) begin
      for (int j = 0; j < 6; j++) begin
        plo12_q[j] <= ACC_W'(aw11_q[j]) * ACC_W'(n_q[11][j][31:0]);
        hi          = ACC_W'(aw11_q[j]) * ACC_W'(n_q[11][j][ACC_W-1:32]);
        phi12_q[j] <= hi[31:0];
      end
      den12_q <= den11_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int f = 0; f < 2; f++) begin
        num13_q[f] <= plo12_q[3*f] + {phi12_q[3*f], 32'd0}
                    + plo12_q[3*f+1] + {phi12_q[3*f+1], 32'd0}
                    + plo12_q[3*f+2] + {phi12_q[3*f+2], 32'd0};
      end
      den13_q <= den12_q;
    end
  end

  // Round to nearest, ties away from zero, on the magnitude.
  always_ff @(posedge clk_i) begin
    logic [DEN_BITS-1:0] dn;
    logic [ACC_W-1:0]    mag;
    logic [ACC_W-1:0]    den6;
    if (en) begin
      for (int f = 0; f < 2; f++) begin
        dn   = (den13_q[f] == '0) ? DEN_BITS'(1) : den13_q[f];
        mag  = num13_q[f][ACC_W-1] ? -num13_q[f] : num13_q[f];
        den6 = ACC_W'(dn) * ACC_W'(6);
        dn14_q[f]  <= (mag << 1) + den6;
        dd14_q[f]  <= DIV_DEN_W'(dn) * DIV_DEN_W'(12);
        neg14_q[f] <= num13_q[f][ACC_W-1];
      end
    end
  end

  for (genvar f = 0; f < 2; f++) begin : g_face
    logic [ACC_W-1:0] qs;
    logic [ACC_W-1:0] sv;

    weno5_div #(
      .NUM_W (ACC_W),
      .DEN_W (DIV_DEN_W)
    ) u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (v_q[NSTG]),
      .num_i   (dn14_q[f]),
      .den_i   (dd14_q[f]),
      .neg_i   (neg14_q[f]),
      .valid_o (div_v[f]),
      .quo_o   (div_q[f]),
      .neg_o   (div_n[f])
    );

    always_comb begin
      if (!div_n[f]) begin
        qs = (div_q[f] > LIM) ? LIM : div_q[f];
      end else begin
        qs = (div_q[f] > LIM + ACC_W'(1)) ? LIM + ACC_W'(1) : div_q[f];
      end
      sv        = div_n[f] ? -qs : qs;
      face_d[f] = sv[DATA_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= div_v[0] && div_v[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      right_q <= face_d[0];
      left_q  <= face_d[1];
    end
  end

  assign out_o.valid            = out_v_q;
  assign out_o.right_face_value = right_q;
  assign out_o.left_face_value  = left_q;
endmodule
